// ===== design/aes_pkg.sv =====
// AES-256 package: types, constants and byte-level functions shared by the block's modules.
package aes_pkg;

    localparam int RoundCount = 14;
    localparam int RkWords    = 4 * (RoundCount + 1);
    localparam int KeyWords   = 8;
    localparam int RkIdxW     = $clog2(RkWords);
    localparam int RoundW     = $clog2(RoundCount + 1);
    localparam logic [1:0] CfgLast = 2'd3;

    typedef enum logic [2:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_FIRST,
        ST_ROUND,
        ST_LAST,
        ST_DONE
    } aes_state_t;

    typedef struct packed {
        logic key_clear;
        logic key_step;
        logic load;
        logic first;
        logic round;
        logic last;
    } aes_cmd_t;

    typedef struct packed {
        logic key_done;
    } aes_status_t;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = t[x];
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        sbox_rev = t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// ===== design/aes_ctrl.sv =====
// AES-256 controller: sequences key expansion and the rounds of one item.
module aes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    output logic                cfg_ready,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  aes_pkg::aes_status_t status,
    output aes_pkg::aes_cmd_t   cmd
);
    import aes_pkg::*;

    aes_state_t state_reg, state_next;
    logic [RoundW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EXPAND;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cfg_ready  = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_EXPAND:
            begin
                cfg_ready = 1'b1;
                if (cfg_write)
                    cmd.key_clear = 1'b1;
                else
                begin
                    cmd.key_step = 1'b1;
                    if (status.key_done)
                        state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_write;
                if (cfg_write)
                begin
                    cmd.key_clear = 1'b1;
                    state_next    = ST_EXPAND;
                end
                else if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                cmd.first  = 1'b1;
                cnt_next   = RoundW'(1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == RoundW'(RoundCount - 1))
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.last   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_FIRST;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/aes_datapath.sv =====
// AES-256 datapath: key registers, key schedule memory and the shared round unit.
module aes_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              op,
    input  logic [63:0]       block_high,
    input  logic [63:0]       block_low,
    input  aes_pkg::aes_cmd_t cmd,
    output aes_pkg::aes_status_t status,
    output logic [63:0]       result_high,
    output logic [63:0]       result_low
);
    import aes_pkg::*;

    logic [63:0]  key_reg [4];
    logic [127:0] rk_reg [RoundCount + 1];
    logic [RkIdxW-1:0] kidx_reg;
    logic [7:0]   rc_reg;
    logic [31:0]  win_reg [KeyWords];
    logic [127:0] st_reg, st_next;
    logic         dec_reg;
    logic [RoundW-1:0] rnd_reg, rnd_next;

    // key schedule: one word per cycle while expanding, eight-word window
    logic [31:0] kw_new, kt;
    logic [2:0]  kmod;
    always_comb
    begin
        kmod = kidx_reg[2:0];
        kt   = win_reg[KeyWords-1];
        if (kmod == 3'd0)
            kt = sub_word({kt[23:0], kt[31:24]}) ^ {rc_reg, 24'h0};
        else if (kmod == 3'd4)
            kt = sub_word(kt);
        if (kidx_reg < RkIdxW'(KeyWords))
            kw_new = kidx_reg[0] ? key_reg[kidx_reg[2:1]][31:0]
                                 : key_reg[kidx_reg[2:1]][63:32];
        else
            kw_new = win_reg[0] ^ kt;
    end

    assign status.key_done = cmd.key_step && (kidx_reg == RkIdxW'(RkWords - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kidx_reg <= '0;
            rc_reg   <= 8'h01;
            key_reg  <= '{default: '0};
        end
        else
        begin
            if (cfg_write && cfg_index <= CfgLast)
                key_reg[cfg_index] <= cfg_data;
            if (cmd.key_clear)
            begin
                kidx_reg <= '0;
                rc_reg   <= 8'h01;
            end
            else if (cmd.key_step)
            begin
                kidx_reg <= status.key_done ? '0 : kidx_reg + 1'b1;
                if (kidx_reg >= RkIdxW'(KeyWords) && kmod == 3'd0)
                    rc_reg <= xt(rc_reg);
            end
        end
    end

    // one entry per round, filled a word lane at a time
    always_ff @(posedge clk)
    begin
        if (cmd.key_step)
        begin
            rk_reg[kidx_reg[RkIdxW-1:2]][{2'd3 - kidx_reg[1:0], 5'd0} +: 32] <= kw_new;
            for (int i = 0; i < KeyWords - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[KeyWords-1] <= kw_new;
        end
    end

    // round key read: memory with registered read data, addressed one round ahead
    logic [RoundW-1:0] rd_round;
    logic [127:0]      rkey_reg;
    always_comb
    begin
        rnd_next = rnd_reg;
        if (cmd.load)
            rnd_next = op ? RoundW'(RoundCount) : '0;
        else if (cmd.first || cmd.round)
            rnd_next = dec_reg ? rnd_reg - 1'b1 : rnd_reg + 1'b1;
        rd_round = rnd_next;
    end

    always_ff @(posedge clk)
    begin
        rkey_reg <= rk_reg[rd_round];
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        st_reg  <= st_next;
        if (cmd.load)
        begin
            dec_reg <= op;
        end
    end

    // round unit
    function automatic logic [7:0] sb(input logic [127:0] s, input int i);
        sb = s[127 - 8 * i -: 8];
    endfunction

    logic [127:0] sh, mx, blk_reg;
    logic [7:0] a0, a1, a2, a3, v;
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                v = dec_reg ? sb(st_reg, r + 4 * ((c + 4 - r) & 3))
                            : sb(st_reg, r + 4 * ((c + r) & 3));
                sh[127 - 8 * (r + 4 * c) -: 8] = dec_reg ? sbox_rev(v) : sbox(v);
            end
        if (dec_reg)
            sh = sh ^ rkey_reg;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a0 = sb(sh, 4 * c + r);
                a1 = sb(sh, 4 * c + ((r + 1) & 3));
                a2 = sb(sh, 4 * c + ((r + 2) & 3));
                a3 = sb(sh, 4 * c + ((r + 3) & 3));
                if (dec_reg)
                    mx[127 - 8 * (4 * c + r) -: 8] =
                        xt(xt(xt(a0))) ^ xt(xt(a0)) ^ xt(a0) ^
                        xt(xt(xt(a1))) ^ xt(a1) ^ a1 ^
                        xt(xt(xt(a2))) ^ xt(xt(a2)) ^ a2 ^
                        xt(xt(xt(a3))) ^ a3;
                else
                    mx[127 - 8 * (4 * c + r) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            end
        end
        st_next = st_reg;
        if (cmd.first)
            st_next = blk_reg ^ rkey_reg;
        else if (cmd.round)
            st_next = dec_reg ? mx : (mx ^ rkey_reg);
        else if (cmd.last)
            st_next = dec_reg ? sh : (sh ^ rkey_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            blk_reg <= {block_high, block_low};
    end

    assign result_high = st_reg[127:64];
    assign result_low  = st_reg[63:0];

endmodule

// ===== design/aes256_block_cipher.sv =====
// AES-256 block cipher top level: joins controller and datapath.
//  channel | signals                                   | dir
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in      | in_valid in_ready op block_high block_low | in
//  out     | out_valid out_ready result_high result_low| out
// A result can be taken once its item has passed through initial key addition,
// thirteen passes through the shared round unit and the final round; the result is then held.
// The next item is accepted in the cycle the result goes, and not while an item is in flight.
// After reset and after every key write the schedule fills 60 words, one a cycle,
// while no item is accepted; a key write during the fill restarts it.
// cfg_ready is low while an item or a waiting result is in flight.
module aes256_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import aes_pkg::*;

    aes_cmd_t    cmd;
    aes_status_t status;
    logic        cfg_write;

    assign cfg_write = cfg_valid && cfg_ready;

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    aes_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .block_high  (block_high),
        .block_low   (block_low),
        .cmd         (cmd),
        .status      (status),
        .result_high (result_high),
        .result_low  (result_low)
    );

endmodule
